// ----- hw/rtl/rebq_pkg.sv -----
package rebq_pkg;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ENC_POLL  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BTN_POLL  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BTN_RESET = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_POS = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_INIT      = 3'd5;

  // button events
  localparam logic [EVENT_W-1:0] EV_IDLE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_CLICK   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENC_EN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_DEB_US = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_DEB_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_MS    = 3'd5;

  // register reset values
  localparam logic [15:0] ENC_DEB_US_RST = 16'd1000;
  localparam logic [7:0]  BTN_DEB_MS_RST = 8'd5;
  localparam logic [15:0] LONG_MS_RST    = 16'd800;
  localparam logic [15:0] MUTE_MS_RST    = 16'd150;

  // quadrature direction, indexed by {old_ab, new_ab}
  localparam logic signed [1:0] QUAD_DIR [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic                encoder_enabled;
    logic                button_enabled;
    logic [15:0]         enc_settle_us;
    logic [7:0]          button_debounce_ms;
    logic [15:0]         hold_long_ms;
    logic [15:0]         mute_ms;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                channel_a_level;
    logic                channel_b_level;
    logic                button_level;
    logic [31:0]         time_us;
    logic [31:0]         time_ms;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  button_event;
    logic signed [31:0]  delta;
    logic signed [31:0]  position;
  } result_t;

endpackage

// ----- hw/rtl/rebq_in_if.sv -----
interface rebq_in_if import rebq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                channel_a_level;
  logic                channel_b_level;
  logic                button_level;
  logic [31:0]         time_us;
  logic [31:0]         time_ms;

  modport source (output valid, action, channel_a_level, channel_b_level, button_level,
                  time_us, time_ms, input ready);
  modport sink   (input valid, action, channel_a_level, channel_b_level, button_level,
                  time_us, time_ms, output ready);
endinterface

// ----- hw/rtl/rebq_out_if.sv -----
interface rebq_out_if import rebq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] button_event;
  logic signed [31:0] delta;
  logic signed [31:0] position;

  modport source (output valid, button_event, delta, position, input ready);
  modport sink   (input valid, button_event, delta, position, output ready);
endinterface

// ----- hw/rtl/rebq_cfg_if.sv -----
interface rebq_cfg_if import rebq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rebq_cfg_regs.sv -----
module rebq_cfg_regs import rebq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.encoder_enabled     <= 1'b1;
      cfg_r.button_enabled      <= 1'b1;
      cfg_r.enc_settle_us       <= ENC_DEB_US_RST;
      cfg_r.button_debounce_ms  <= BTN_DEB_MS_RST;
      cfg_r.hold_long_ms        <= LONG_MS_RST;
      cfg_r.mute_ms             <= MUTE_MS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENC_EN:     cfg_r.encoder_enabled     <= wr_data[0];
        REG_BTN_EN:     cfg_r.button_enabled      <= wr_data[0];
        REG_ENC_DEB_US: cfg_r.enc_settle_us       <= wr_data;
        REG_BTN_DEB_MS: cfg_r.button_debounce_ms  <= wr_data[7:0];
        REG_LONG_MS:    cfg_r.hold_long_ms        <= wr_data;
        REG_MUTE_MS:    cfg_r.mute_ms             <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/rebq_core.sv -----
module rebq_core import rebq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [1:0]  quad_r,     quad_nxt;
  logic [31:0] pos_r,      pos_nxt;
  logic [31:0] last_us_r,  last_us_nxt;
  logic [31:0] mute_r,     mute_nxt;
  logic [31:0] dstart_r,   dstart_nxt;
  logic        deb_r,      deb_nxt;
  logic        held_r,     held_nxt;
  logic        used_r,     used_nxt;
  logic [31:0] pstart_r,   pstart_nxt;

  logic [1:0]         quad_now;
  logic               down;
  logic [31:0]        us_diff;
  logic [31:0]        deb_diff;
  logic [31:0]        held_diff;
  logic [31:0]        mute_at;
  logic signed [1:0]  dir;
  logic [EVENT_W-1:0] ev;
  logic [31:0]        delta;

  assign quad_now  = {item.channel_a_level, item.channel_b_level};
  assign down      = ~item.button_level;
  assign us_diff   = item.time_us - last_us_r;
  assign deb_diff  = item.time_ms - dstart_r;
  assign held_diff = item.time_ms - pstart_r;
  assign mute_at   = item.time_ms + {16'd0, cfg.mute_ms};
  assign dir       = QUAD_DIR[{quad_r, quad_now}];

  always_comb begin
    quad_nxt    = quad_r;
    pos_nxt     = pos_r;
    last_us_nxt = last_us_r;
    mute_nxt    = mute_r;
    dstart_nxt  = dstart_r;
    deb_nxt     = deb_r;
    held_nxt    = held_r;
    used_nxt    = used_r;
    pstart_nxt  = pstart_r;
    ev          = EV_IDLE;
    delta       = 32'd0;

    case (item.action)
      ACT_ENC_POLL: begin
        if (cfg.encoder_enabled) begin
          if (quad_now != quad_r) begin
            if (us_diff >= {16'd0, cfg.enc_settle_us}) begin
              pos_nxt     = pos_r - {{30{dir[1]}}, dir};
              quad_nxt    = quad_now;
              last_us_nxt = item.time_us;
            end
          end else begin
            last_us_nxt = item.time_us;
          end
        end
      end
      ACT_BTN_POLL: begin
        if (cfg.button_enabled) begin
          if (down && !held_r && !deb_r) begin
            dstart_nxt = item.time_ms;
            deb_nxt    = 1'b1;
            mute_nxt   = mute_at;
          end else if (deb_r) begin
            if (down && deb_diff >= {24'd0, cfg.button_debounce_ms}) begin
              held_nxt   = 1'b1;
              deb_nxt    = 1'b0;
              pstart_nxt = item.time_ms;
              used_nxt   = 1'b0;
              ev         = EV_PRESSED;
            end else if (!down) begin
              deb_nxt = 1'b0;
            end
          end else if (down && held_r && !used_r &&
                       held_diff >= {16'd0, cfg.hold_long_ms}) begin
            used_nxt = 1'b1;
            ev       = EV_LONG;
          end else if (!down && held_r) begin
            held_nxt = 1'b0;
            mute_nxt = mute_at;
            if (!used_r) ev = EV_CLICK;
          end
        end
      end
      ACT_READ: begin
        // muted reads still drop the count
        if (item.time_ms >= mute_r) delta = pos_r;
        pos_nxt = 32'd0;
      end
      ACT_BTN_RESET: begin
        held_nxt   = 1'b0;
        used_nxt   = 1'b1;
        pstart_nxt = 32'd0;
        deb_nxt    = 1'b0;
      end
      ACT_CLEAR_POS: pos_nxt = 32'd0;
      ACT_INIT: begin
        pos_nxt     = 32'd0;
        quad_nxt    = cfg.encoder_enabled ? quad_now : 2'd0;
        last_us_nxt = cfg.encoder_enabled ? item.time_us : 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r    <= 2'd0;
      pos_r     <= 32'd0;
      last_us_r <= 32'd0;
      mute_r    <= 32'd0;
      dstart_r  <= 32'd0;
      deb_r     <= 1'b0;
      held_r    <= 1'b0;
      used_r    <= 1'b0;
      pstart_r  <= 32'd0;
    end else if (step) begin
      quad_r    <= quad_nxt;
      pos_r     <= pos_nxt;
      last_us_r <= last_us_nxt;
      mute_r    <= mute_nxt;
      dstart_r  <= dstart_nxt;
      deb_r     <= deb_nxt;
      held_r    <= held_nxt;
      used_r    <= used_nxt;
      pstart_r  <= pstart_nxt;
    end
  end

  assign res.button_event = ev;
  assign res.delta        = delta;
  assign res.position     = pos_nxt;

endmodule

// ----- hw/rtl/rotary_encoder_button_qualifier_unit.sv -----
// channel   dir  handshake     beat carries
// in_bus    in   valid/ready   action, A/B levels, button level, time_us, time_ms
// out_bus   out  valid/ready   button_event, delta, position
// cfg_bus   in   valid/ready   register index, write data (always ready)
//
// One item per cycle sustained while out_bus is ready; each beat passes through, in order:
// an input register, then the decode/debounce step feeding the result register.
// State updates when an item moves into the result register.
// A stalled result holds the pipe; the input register still takes one more beat.
// Synchronous active-low reset clears the valid flags and core state and loads register defaults.
module rotary_encoder_button_qualifier_unit import rebq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rebq_in_if.sink     in_bus,
  rebq_out_if.source  out_bus,
  rebq_cfg_if.sink    cfg_bus
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    advance;

  assign advance      = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || advance;
  assign cfg_bus.ready = 1'b1;

  rebq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  rebq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_bus.ready) in_vld_r <= in_bus.valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_bus.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.action          <= in_bus.action;
      item_r.channel_a_level <= in_bus.channel_a_level;
      item_r.channel_b_level <= in_bus.channel_b_level;
      item_r.button_level    <= in_bus.button_level;
      item_r.time_us         <= in_bus.time_us;
      item_r.time_ms         <= in_bus.time_ms;
    end
    if (advance) res_r <= res;
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.button_event = res_r.button_event;
  assign out_bus.delta        = res_r.delta;
  assign out_bus.position     = res_r.position;

endmodule
